/* hw/rtl/snda_pkg.sv */
// Shared types and constants of the self-organizing-map neuron block.
// No dependencies; every other file of the block imports this package.

package snda_pkg;

    // Default vector length.
    localparam int NUM_SAMPLES_DEF = 4096;

    // Field widths of the stream items.
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 24;
    localparam int RATE_W = 17;
    localparam int SUM_W  = 60;
    localparam int WIN_W  = 13;

    // Bus widths; the stream widths are padded to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 1;

    // Datapath widths: difference, shared multiplier operand and product.
    localparam int DIFF_W  = VAL_W + 1;
    localparam int MULA_W  = DIFF_W + 1;
    localparam int PROD_W  = MULA_W + DIFF_W;
    localparam int SQ_W    = 2 * VAL_W + 1;
    localparam int SHIFT   = 16;
    localparam int DELTA_W = PROD_W - SHIFT;
    localparam int NW_W    = DELTA_W + 1;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPARE = 2'd1,
        CMD_ADAPT   = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_START = 1'b0,
        CFG_WINDOW_END   = 1'b1
    } cfg_idx_t;

    localparam logic [WIN_W-1:0] WINDOW_START_RST = 13'd0;
    localparam logic [WIN_W-1:0] WINDOW_END_RST   = 13'd4096;

    localparam logic [SUM_W-1:0]        SUM_MAX = '1;
    localparam logic signed [VAL_W-1:0] W_MAX   = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] W_MIN   = 24'sh800000;

    // One input item as it moves into the first stage.
    typedef struct packed {
        cmd_t                      cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [VAL_W-1:0]   x;
        logic [RATE_W-1:0]         rate;
        logic                      last;
    } item_t;

endpackage

/* hw/rtl/snda_weight_ram.sv */
// Weight memory of the neuron: one write port, one registered read port,
// and a zero-fill sweep after reset. Depends on snda_pkg.

module snda_weight_ram
    import snda_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int AW          = $clog2(NUM_SAMPLES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [VAL_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [VAL_W-1:0] wr_data,
    output logic             busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SAMPLES - 1);

    logic [VAL_W-1:0] mem [NUM_SAMPLES];
    logic [VAL_W-1:0] rd_data_reg;
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;

    // Clearing sweep: one entry per cycle from address zero up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port, shared between the sweep and the datapath.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a same-cycle write is not seen.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

/* hw/rtl/som_neuron_distance_and_adapt.sv */
// Top level of the self-organizing-map neuron: distance and weight adaption.
// Depends on snda_pkg and snda_weight_ram.

// The neuron takes one sample per cycle on the input stream unless stalled, and
// gives a distance result for the compare item that carries tlast after the
// first and second stages, in an output register. Once after reset the weight
// memory is swept to zero, while s_tready stays low; configuration writes are
// taken at all times. The weight read-modify-write runs over the memory read,
// one multiplier stage and one add-and-saturate stage, so a compare or adapt
// item that directly follows an adapt item on the same in-window index waits
// in the first stage for that write-back. A second result that finds the output
// register still full holds the pipe until the first one is taken.

module som_neuron_distance_and_adapt
    import snda_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // sample_index, sample_value, rate, zero pad
    input  logic [CMD_W-1:0]     s_tuser,  // command
    input  logic                 s_tlast,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // distance_sum, zero pad
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data
);

    localparam int AW = $clog2(NUM_SAMPLES);

    // Configuration registers.
    logic [WIN_W-1:0] win_start_reg;
    logic [WIN_W-1:0] win_end_reg;

    // First stage: the accepted item, waiting for its weight read.
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // Second stage: product and what write-back needs.
    logic                     s2_valid_reg;
    cmd_t                     s2_cmd_reg;
    logic                     s2_last_reg;
    logic                     s2_in_win_reg;
    logic                     s2_we_reg;
    logic [AW-1:0]            s2_addr_reg;
    logic signed [VAL_W-1:0]  s2_x_reg;
    logic signed [VAL_W-1:0]  s2_w_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    // Last write to the memory, for forwarding.
    logic                 wb_valid_reg;
    logic [AW-1:0]        wb_addr_reg;
    logic [VAL_W-1:0]     wb_data_reg;

    // Running sum and output register.
    logic [SUM_W-1:0] sum_reg;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_data_reg;

    item_t                    in_item;
    logic                     accept;
    logic                     ram_busy;
    logic [VAL_W-1:0]         rd_data;
    logic                     wr_en;
    logic [VAL_W-1:0]         wr_data;

    logic                     s1_idx_ok;
    logic                     s1_in_win;
    logic [AW-1:0]            s1_addr;
    logic                     s1_we;
    logic                     s1_uses_w;
    logic signed [VAL_W-1:0]  s1_w;
    logic                     hazard;
    logic                     s1_hold;
    logic                     s1_move;
    logic signed [DIFF_W-1:0] diff;
    logic signed [MULA_W-1:0] mul_a;
    logic signed [PROD_W-1:0] prod;

    logic [SQ_W-1:0]          sq;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_new;
    logic signed [DELTA_W-1:0] delta;
    logic signed [NW_W-1:0]   nw_wide;
    logic signed [VAL_W-1:0]  nw_sat;
    logic                     emit;
    logic                     hold2;
    logic                     s2_adv;

    // Unpack the input transfer.
    always_comb
    begin
        in_item.cmd  = cmd_t'(s_tuser);
        in_item.idx  = s_tdata[IDX_W-1:0];
        in_item.x    = s_tdata[IDX_W+VAL_W-1:IDX_W];
        in_item.rate = s_tdata[IDX_W+VAL_W+RATE_W-1:IDX_W+VAL_W];
        in_item.last = s_tlast;
    end

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= WINDOW_START_RST;
            win_end_reg   <= WINDOW_END_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_START: win_start_reg <= cfg_data;
                CFG_WINDOW_END:   win_end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    snda_weight_ram #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .AW          (AW)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (AW'(in_item.idx)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (wr_data),
        .busy    (ram_busy)
    );

    // First stage: window test and weight selection with forwarding.
    always_comb
    begin
        s1_idx_ok = 32'(s1_item_reg.idx) < NUM_SAMPLES;
        s1_in_win = s1_idx_ok && (WIN_W'(s1_item_reg.idx) >= win_start_reg)
                    && (WIN_W'(s1_item_reg.idx) < win_end_reg);
        s1_addr   = AW'(s1_item_reg.idx);
        s1_we     = ((s1_item_reg.cmd == CMD_LOAD) && s1_idx_ok)
                    || ((s1_item_reg.cmd == CMD_ADAPT) && s1_in_win);
        s1_uses_w = ((s1_item_reg.cmd == CMD_COMPARE) || (s1_item_reg.cmd == CMD_ADAPT))
                    && s1_in_win;

        if (s2_valid_reg && s2_we_reg && (s2_cmd_reg == CMD_LOAD)
            && (s2_addr_reg == s1_addr))
        begin
            s1_w = s2_x_reg;
        end
        else if (wb_valid_reg && (wb_addr_reg == s1_addr))
        begin
            s1_w = wb_data_reg;
        end
        else
        begin
            s1_w = rd_data;
        end

        // An adapt in the second stage still owes its write-back.
        hazard = s1_valid_reg && s1_uses_w && s2_valid_reg && s2_we_reg
                 && (s2_cmd_reg == CMD_ADAPT) && (s2_addr_reg == s1_addr);
    end

    // Shared multiplier: squared difference or rate times difference.
    always_comb
    begin
        diff  = DIFF_W'(s1_item_reg.x) - DIFF_W'(s1_w);
        mul_a = (s1_item_reg.cmd == CMD_ADAPT) ? signed'(MULA_W'(s1_item_reg.rate))
                                               : MULA_W'(diff);
        prod  = mul_a * diff;
    end

    // Second stage: accumulate with saturation, or new weight with saturation.
    always_comb
    begin
        sq      = s2_prod_reg[SQ_W-1:0];
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq);
        if (!s2_in_win_reg)
        begin
            sum_new = sum_reg;
        end
        else if (sum_add[SUM_W])
        begin
            sum_new = SUM_MAX;
        end
        else
        begin
            sum_new = sum_add[SUM_W-1:0];
        end

        // Arithmetic shift rounds toward minus infinity.
        delta   = s2_prod_reg[PROD_W-1:SHIFT];
        nw_wide = NW_W'(delta) + NW_W'(s2_w_reg);
        if (nw_wide > NW_W'(W_MAX))
        begin
            nw_sat = W_MAX;
        end
        else if (nw_wide < NW_W'(W_MIN))
        begin
            nw_sat = W_MIN;
        end
        else
        begin
            nw_sat = nw_wide[VAL_W-1:0];
        end

        emit    = s2_valid_reg && (s2_cmd_reg == CMD_COMPARE) && s2_last_reg;
        hold2   = emit && out_valid_reg && !m_tready;
        s2_adv  = s2_valid_reg && !hold2;
        wr_en   = s2_adv && s2_we_reg;
        wr_data = (s2_cmd_reg == CMD_LOAD) ? s2_x_reg : nw_sat;
    end

    // Stall control.
    assign s1_hold  = s1_valid_reg && (hazard || hold2);
    assign s1_move  = s1_valid_reg && !s1_hold;
    assign s_tready = !ram_busy && !s1_hold;

    // Pipeline valid bits, write-back tracking, running sum and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (!s1_hold)
            begin
                s1_valid_reg <= accept;
            end
            if (!hold2)
            begin
                s2_valid_reg <= s1_move;
            end
            if (wr_en)
            begin
                wb_valid_reg <= 1'b1;
            end
            if (s2_adv && (s2_cmd_reg == CMD_COMPARE))
            begin
                sum_reg <= s2_last_reg ? '0 : sum_new;
            end
            if (emit && !hold2)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move && !hold2)
        begin
            s2_cmd_reg    <= s1_item_reg.cmd;
            s2_last_reg   <= s1_item_reg.last;
            s2_in_win_reg <= s1_in_win;
            s2_we_reg     <= s1_we;
            s2_addr_reg   <= s1_addr;
            s2_x_reg      <= s1_item_reg.x;
            s2_w_reg      <= s1_w;
            s2_prod_reg   <= prod;
        end
        if (wr_en)
        begin
            wb_addr_reg <= s2_addr_reg;
            wb_data_reg <= wr_data;
        end
        if (emit && !hold2)
        begin
            out_data_reg <= sum_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

endmodule

/* hw/rtl/snda_checker.sv */
// Port-level checks of the neuron block and the bind that attaches them.
// Depends on snda_pkg and the top level som_neuron_distance_and_adapt.

module snda_checker
    import snda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CMD_W-1:0]     s_tuser,  // command
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // distance_sum, zero pad
    input  logic                 cfg_valid,
    input  logic                 cfg_ready
);

    logic [2:0] pend_reg;
    logic       inc;
    logic       dec;

    // Results owed: accepted closing compare items not yet delivered.
    assign inc = s_tvalid && s_tready && (s_tuser == CMD_COMPARE) && s_tlast;
    assign dec = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (inc && !dec)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (dec && !inc)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    // The memory sweep keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_tready)
        else $error("input accepted during the clearing sweep");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result without a closing compare item before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 3'd0)
        else $error("result without a closing compare item");

    // At most three results are in flight: two stages and the output register.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("too many results in flight");

    // Configuration is never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer refused");

endmodule

bind som_neuron_distance_and_adapt snda_checker u_snda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
